@@ design/mdvt_pkg.sv @@
// Package for the muon deadtime veto tracker: field widths, request and
// result types, register indexes, reset values and the tick-to-ns helper.
// No dependencies.
package mdvt_pkg;

    localparam int HITS_W   = 14;
    localparam int WORD_W   = 64;
    localparam int TICK_W   = 43;
    localparam int WIN_W    = 48;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // stream payload widths
    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 160;
    localparam int M_TUSER_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VETO_WINDOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MUON_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOWER_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_MASK      = 3'd4;

    // register reset values
    localparam logic [HITS_W-1:0] RST_HIT_LIMIT     = 14'd5000;
    localparam logic [WIN_W-1:0]  RST_VETO_WINDOW   = 48'd20000000000;
    localparam logic [WORD_W-1:0] RST_MUON_MASK     = 64'h80;
    localparam logic [WORD_W-1:0] RST_FOLLOWER_MASK = 64'h4000;
    localparam logic [WORD_W-1:0] RST_CUT_MASK      = 64'h2100_0000_42C2;

    typedef enum logic [2:0] {
        V_PASS      = 3'd0,
        V_NEW_VETO  = 3'd1,
        V_PILEUP    = 3'd2,
        V_IN_WINDOW = 3'd3,
        V_FOLLOWER  = 3'd4,
        V_CUT_FAIL  = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [HITS_W-1:0] event_hits;
        logic              words_valid;
        logic [WORD_W-1:0] applied_word;
        logic [WORD_W-1:0] flagged_word;
        logic [TICK_W-1:0] tick_time;
    } t_item;

    typedef struct packed {
        t_verdict           verdict;
        logic [COUNT_W-1:0] veto_total;
        logic [SUM_W-1:0]   pileup_ns;
        logic [SUM_W-1:0]   follower_ns;
    } t_result;

    typedef struct packed {
        logic [HITS_W-1:0] hit_limit;
        logic [WIN_W-1:0]  veto_window_ns;
        logic [WORD_W-1:0] muon_pass_mask;
        logic [WORD_W-1:0] follower_pass_mask;
        logic [WORD_W-1:0] cut_mask;
    } t_cfg;

    // elapsed ticks modulo 2^43 times 20 ns, as 16x + 4x
    function automatic logic [WIN_W-1:0] elapsed_ns(input logic [TICK_W-1:0] now,
                                                     input logic [TICK_W-1:0] start);
        logic [TICK_W-1:0] d;
        logic [WIN_W-1:0]  dx;
        d  = now - start;
        dx = {{(WIN_W-TICK_W){1'b0}}, d};
        return (dx << 4) + (dx << 2);
    endfunction

endpackage

@@ design/mdvt_cfg.sv @@
// Configuration registers of the veto tracker, written through a plain
// write port. Depends on mdvt_pkg.
module mdvt_cfg import mdvt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hit_limit          <= RST_HIT_LIMIT;
            r_cfg.veto_window_ns     <= RST_VETO_WINDOW;
            r_cfg.muon_pass_mask     <= RST_MUON_MASK;
            r_cfg.follower_pass_mask <= RST_FOLLOWER_MASK;
            r_cfg.cut_mask           <= RST_CUT_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HIT_LIMIT:     r_cfg.hit_limit          <= i_cfg_data[HITS_W-1:0];
                CFG_VETO_WINDOW:   r_cfg.veto_window_ns     <= i_cfg_data[WIN_W-1:0];
                CFG_MUON_MASK:     r_cfg.muon_pass_mask     <= i_cfg_data[WORD_W-1:0];
                CFG_FOLLOWER_MASK: r_cfg.follower_pass_mask <= i_cfg_data[WORD_W-1:0];
                CFG_CUT_MASK:      r_cfg.cut_mask           <= i_cfg_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/mdvt_in_stage.sv @@
// Input register of the veto tracker: holds one request until the core
// takes it. Depends on mdvt_pkg.
module mdvt_in_stage import mdvt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ design/mdvt_core.sv @@
// Verdict logic and tracker state: veto and follower windows, veto count,
// saturating deadtime totals and the held cleaning words. Depends on mdvt_pkg.
module mdvt_core import mdvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic               r_veto_active, n_veto_active;
    logic               r_follower_active, n_follower_active;
    logic [TICK_W-1:0]  r_veto_start, n_veto_start;
    logic [TICK_W-1:0]  r_follower_start, n_follower_start;
    logic [COUNT_W-1:0] r_veto_count, n_veto_count;
    logic [SUM_W-1:0]   r_pileup_sum, n_pileup_sum;
    logic [SUM_W-1:0]   r_follower_sum, n_follower_sum;
    logic [WORD_W-1:0]  r_held_applied, r_held_flagged;

    logic [WORD_W-1:0]  flags, applied, need;
    logic [WIN_W-1:0]   el_veto, el_follower;
    logic [SUM_W:0]     pileup_add, follower_add;
    logic [SUM_W-1:0]   pileup_sat, follower_sat;
    logic               is_muon, follower_ok;
    t_verdict           verdict;

    assign flags   = i_item.words_valid ? i_item.flagged_word : r_held_flagged;
    assign applied = i_item.words_valid ? i_item.applied_word : r_held_applied;

    assign el_veto     = elapsed_ns(i_item.tick_time, r_veto_start);
    assign el_follower = elapsed_ns(i_item.tick_time, r_follower_start);

    assign pileup_add   = {1'b0, r_pileup_sum} + {{(SUM_W+1-WIN_W){1'b0}}, el_veto};
    assign follower_add = {1'b0, r_follower_sum} + {{(SUM_W+1-WIN_W){1'b0}}, el_follower};
    assign pileup_sat   = pileup_add[SUM_W] ? '1 : pileup_add[SUM_W-1:0];
    assign follower_sat = follower_add[SUM_W] ? '1 : follower_add[SUM_W-1:0];

    assign is_muon = (i_item.event_hits > i_cfg.hit_limit)
                  || ((flags & i_cfg.muon_pass_mask) != i_cfg.muon_pass_mask);
    assign follower_ok = (flags & i_cfg.follower_pass_mask) == i_cfg.follower_pass_mask;
    assign need = applied & i_cfg.cut_mask;

    always_comb begin
        n_veto_active     = r_veto_active;
        n_follower_active = r_follower_active;
        n_veto_start      = r_veto_start;
        n_follower_start  = r_follower_start;
        n_veto_count      = r_veto_count;
        n_pileup_sum      = r_pileup_sum;
        n_follower_sum    = r_follower_sum;
        verdict           = V_PASS;
        if (is_muon) begin
            // a muon closes any open follower window first
            if (r_follower_active) begin
                n_follower_sum    = follower_sat;
                n_follower_active = 1'b0;
            end
            n_veto_start = i_item.tick_time;
            if (!r_veto_active) begin
                if (r_veto_count != '1) begin
                    n_veto_count = r_veto_count + 1'b1;
                end
                n_veto_active = 1'b1;
                verdict       = V_NEW_VETO;
            end else begin
                n_pileup_sum = pileup_sat;
                verdict      = V_PILEUP;
            end
        end else if (r_veto_active && (el_veto < i_cfg.veto_window_ns)) begin
            verdict = V_IN_WINDOW;
        end else begin
            // window expired or closed: judge further
            n_veto_active = 1'b0;
            if (!follower_ok) begin
                if (r_follower_active) begin
                    n_follower_sum = follower_sat;
                end
                n_follower_active = 1'b1;
                n_follower_start  = i_item.tick_time;
                verdict           = V_FOLLOWER;
            end else begin
                n_follower_active = 1'b0;
                verdict = ((need & flags) != need) ? V_CUT_FAIL : V_PASS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_veto_active     <= 1'b0;
            r_follower_active <= 1'b0;
            r_veto_start      <= '0;
            r_follower_start  <= '0;
            r_veto_count      <= '0;
            r_pileup_sum      <= '0;
            r_follower_sum    <= '0;
            r_held_applied    <= '0;
            r_held_flagged    <= '0;
        end else if (i_fire) begin
            r_veto_active     <= n_veto_active;
            r_follower_active <= n_follower_active;
            r_veto_start      <= n_veto_start;
            r_follower_start  <= n_follower_start;
            r_veto_count      <= n_veto_count;
            r_pileup_sum      <= n_pileup_sum;
            r_follower_sum    <= n_follower_sum;
            r_held_applied    <= applied;
            r_held_flagged    <= flags;
        end
    end

    assign o_result.verdict     = verdict;
    assign o_result.veto_total  = n_veto_count;
    assign o_result.pileup_ns   = n_pileup_sum;
    assign o_result.follower_ns = n_follower_sum;

    // totals never go down
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_veto_count >= $past(r_veto_count))
        else $error("veto count decreased");

    a_pileup_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_pileup_sum >= $past(r_pileup_sum))
        else $error("pileup total decreased");

    a_follower_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_follower_sum >= $past(r_follower_sum))
        else $error("follower total decreased");

    a_new_veto_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (verdict == V_NEW_VETO || verdict == V_PILEUP))
        |=> (r_veto_active && !r_follower_active))
        else $error("muon event did not leave an open veto window");

endmodule

@@ design/mdvt_out_stage.sv @@
// Output register of the veto tracker: holds one result until the
// downstream side takes it. Depends on mdvt_pkg.
module mdvt_out_stage import mdvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_room = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ design/muon_deadtime_veto_tracker.sv @@
// Muon deadtime veto tracker, top level.
// The accepting edge loads the input register; when the output stage has room, the
// verdict logic output is loaded into the output register.
// Throughput: 1 request per cycle unless output stalls; verdict/state loop sets it.
// Reset: synchronous active-low i_rst_n clears windows, counters, held words
// and both stages, and loads the register defaults.
module muon_deadtime_veto_tracker import mdvt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // event_hits[13:0], applied_word[77:14], flagged_word[141:78],
    // tick_time[184:142], zero fill[191:185]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // words_valid[0]
    input  logic                  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // veto_total[31:0], pileup_ns[95:32], follower_ns[159:96]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // verdict[2:0]
    output logic [M_TUSER_W-1:0]  o_m_tuser
);

    t_cfg    cfg;
    t_item   s_item, core_item;
    t_result core_result, out_result;
    logic    core_valid, out_room, fire;

    assign s_item.event_hits   = i_s_tdata[13:0];
    assign s_item.words_valid  = i_s_tuser;
    assign s_item.applied_word = i_s_tdata[77:14];
    assign s_item.flagged_word = i_s_tdata[141:78];
    assign s_item.tick_time    = i_s_tdata[184:142];

    assign fire = core_valid && out_room;

    mdvt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mdvt_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (s_item),
        .i_take  (fire),
        .o_valid (core_valid),
        .o_item  (core_item)
    );

    mdvt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (core_item),
        .o_result (core_result)
    );

    mdvt_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (core_result),
        .o_room   (out_room),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    assign o_m_tdata = {out_result.follower_ns, out_result.pileup_ns, out_result.veto_total};
    assign o_m_tuser = out_result.verdict;

endmodule

@@ tb/tb_muon_deadtime_veto_tracker.sv @@
// Self-checking testbench for muon_deadtime_veto_tracker: directed and random event
// streams checked against a cycle-free predictor of the veto/follower bookkeeping.
// Depends on mdvt_pkg and the tracker RTL only.
`timescale 1ns / 100ps

module tb_muon_deadtime_veto_tracker;
    import mdvt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;  // not decoded by the block

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // event_hits[13:0], applied_word[77:14], flagged_word[141:78],
    // tick_time[184:142], zero fill[191:185]
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;
    // words_valid[0]
    logic                  i_s_tuser  = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // veto_total[31:0], pileup_ns[95:32], follower_ns[159:96]
    logic [M_TDATA_W-1:0]  o_m_tdata;
    // verdict[2:0]
    logic [M_TUSER_W-1:0]  o_m_tuser;

    muon_deadtime_veto_tracker DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [HITS_W-1:0] lim_hits;
    logic [WIN_W-1:0]  win_ns;
    logic [WORD_W-1:0] muon_req;
    logic [WORD_W-1:0] follower_req;
    logic [WORD_W-1:0] cut_req;

    // predictor copy of the tracker state
    logic              veto_open;
    logic              follower_open;
    logic [TICK_W-1:0] veto_origin;
    logic [TICK_W-1:0] follower_origin;
    logic [31:0]       windows_opened;
    logic [63:0]       pileup_acc;
    logic [63:0]       follower_acc;
    logic [63:0]       kept_applied;
    logic [63:0]       kept_flagged;

    t_result verdict_q[$];
    int      mismatches = 0;

    // stimulus shaping
    logic [TICK_W-1:0] tick_now    = '0;
    int unsigned       tick_stride = 50;
    int                burst_left  = 0;

    // receiver stall pattern
    int sink_cycle  = 0;
    int sink_period = 1;
    int sink_duty   = 0;

    function automatic logic [63:0] span_ns(input logic [TICK_W-1:0] now,
                                            input logic [TICK_W-1:0] origin);
        logic [TICK_W-1:0] ticks;
        ticks = now - origin;
        return 64'(ticks) * 64'd20;
    endfunction

    function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    task automatic clear_tracker();
        lim_hits        = RST_HIT_LIMIT;
        win_ns          = RST_VETO_WINDOW;
        muon_req        = RST_MUON_MASK;
        follower_req    = RST_FOLLOWER_MASK;
        cut_req         = RST_CUT_MASK;
        veto_open       = 1'b0;
        follower_open   = 1'b0;
        veto_origin     = '0;
        follower_origin = '0;
        windows_opened  = '0;
        pileup_acc      = '0;
        follower_acc    = '0;
        kept_applied    = '0;
        kept_flagged    = '0;
    endtask

    function automatic t_result judge_event(input t_item ev);
        t_result     r;
        t_verdict    v;
        logic [63:0] flags;
        logic [63:0] need;
        if (ev.words_valid) begin
            kept_applied = ev.applied_word;
            kept_flagged = ev.flagged_word;
        end
        flags = kept_flagged;
        if (ev.event_hits > lim_hits || (flags & muon_req) != muon_req) begin
            // a muon ends any lone-follower window first
            if (follower_open) begin
                follower_acc  = add_clamped(follower_acc, span_ns(ev.tick_time, follower_origin));
                follower_open = 1'b0;
            end
            if (!veto_open) begin
                if (windows_opened != '1)
                    windows_opened = windows_opened + 32'd1;
                veto_open = 1'b1;
                v = V_NEW_VETO;
            end else begin
                pileup_acc = add_clamped(pileup_acc, span_ns(ev.tick_time, veto_origin));
                v = V_PILEUP;
            end
            veto_origin = ev.tick_time;
        end else if (veto_open && span_ns(ev.tick_time, veto_origin) < 64'(win_ns)) begin
            v = V_IN_WINDOW;
        end else begin
            veto_open = 1'b0;
            if ((flags & follower_req) != follower_req) begin
                if (follower_open)
                    follower_acc = add_clamped(follower_acc, span_ns(ev.tick_time, follower_origin));
                follower_open   = 1'b1;
                follower_origin = ev.tick_time;
                v = V_FOLLOWER;
            end else begin
                follower_open = 1'b0;
                need = kept_applied & cut_req;
                v = ((need & flags) != need) ? V_CUT_FAIL : V_PASS;
            end
        end
        r.verdict     = v;
        r.veto_total  = windows_opened;
        r.pileup_ns   = pileup_acc;
        r.follower_ns = follower_acc;
        return r;
    endfunction

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result: expected none actual verdict %0d",
                         $time, o_m_tuser);
                mismatches++;
            end else begin
                want = verdict_q.pop_front();
                report_field("verdict", 64'(want.verdict), 64'(o_m_tuser));
                report_field("veto_total", 64'(want.veto_total), 64'(o_m_tdata[31:0]));
                report_field("pileup_ns", want.pileup_ns, o_m_tdata[95:32]);
                report_field("follower_ns", want.follower_ns, o_m_tdata[159:96]);
            end
        end
    end

    // receiver: duty-cycled stalls with a randomly redrawn period and duty
    always @(posedge i_clk) begin : sink_stalls
        if (sink_cycle % 48 == 0) begin
            sink_period = $urandom_range(1, 8);
            sink_duty   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, sink_period - 1);
        end
        i_m_tready <= (sink_cycle % sink_period) >= sink_duty;
        sink_cycle++;
    end

    task automatic send_event(input t_item ev);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'b0, ev.tick_time, ev.flagged_word, ev.applied_word, ev.event_hits};
        i_s_tuser  <= ev.words_valid;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // append the expected result at the tail
        verdict_q = {verdict_q, judge_event(ev)};
        burst_left--;
    endtask

    // hold the sender until every pending result is back, then let the pipe empty
    task automatic settle_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HIT_LIMIT:     lim_hits     = value[HITS_W-1:0];
            CFG_VETO_WINDOW:   win_ns       = value[WIN_W-1:0];
            CFG_MUON_MASK:     muon_req     = value;
            CFG_FOLLOWER_MASK: follower_req = value;
            CFG_CUT_MASK:      cut_req      = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [63:0] hits, input logic [63:0] window,
                                 input logic [63:0] muon, input logic [63:0] follower,
                                 input logic [63:0] cut);
        write_register(CFG_HIT_LIMIT, hits);
        write_register(CFG_VETO_WINDOW, window);
        write_register(CFG_MUON_MASK, muon);
        write_register(CFG_FOLLOWER_MASK, follower);
        write_register(CFG_CUT_MASK, cut);
    endtask

    function automatic logic [63:0] few_bits();
        return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
    endfunction

    function automatic t_item build_event(input logic [HITS_W-1:0] hits, input logic valid,
                                          input logic [63:0] applied, input logic [63:0] flagged,
                                          input logic [TICK_W-1:0] tick);
        t_item ev;
        ev.event_hits   = hits;
        ev.words_valid  = valid;
        ev.applied_word = applied;
        ev.flagged_word = flagged;
        ev.tick_time    = tick;
        return ev;
    endfunction

    // mostly well-formed events near the current settings, some noise
    function automatic t_item random_event();
        t_item       ev;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            tick_now = TICK_W'({$urandom, $urandom});
        else if (roll < 8)
            tick_now = tick_now + TICK_W'($urandom);
        else
            tick_now = tick_now + TICK_W'($urandom_range(0, tick_stride));
        ev.tick_time = tick_now;
        roll = $urandom_range(0, 99);
        if (roll < 12 && lim_hits != '1)
            ev.event_hits = HITS_W'($urandom_range(lim_hits + 1, 16383));
        else if (roll < 18)
            ev.event_hits = HITS_W'($urandom_range(0, 16383));
        else if (roll < 23)
            ev.event_hits = lim_hits;
        else
            ev.event_hits = HITS_W'($urandom_range(0, lim_hits));
        ev.words_valid  = ($urandom_range(0, 3) != 0);
        ev.applied_word = $urandom_range(0, 1) ? {$urandom, $urandom} : few_bits();
        ev.flagged_word = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 85)
            ev.flagged_word = ev.flagged_word | muon_req;
        if ($urandom_range(0, 99) < 85)
            ev.flagged_word = ev.flagged_word | follower_req;
        if ($urandom_range(0, 99) < 60)
            ev.flagged_word = ev.flagged_word | (ev.applied_word & cut_req);
        return ev;
    endfunction

    task automatic run_traffic(input int count);
        repeat (count) begin
            send_event(random_event());
            if ($urandom_range(0, 59) == 0)
                settle_results();
        end
    endtask

    // runs at reset settings: every verdict, window edges, clock wrap, stale words
    task automatic test_directed_cases();
        logic [63:0]       good;
        logic [TICK_W-1:0] t;
        good = RST_CUT_MASK | RST_MUON_MASK | RST_FOLLOWER_MASK;
        // held words still zero, so the muon flag is missing
        send_event(build_event(14'd0, 1'b0, '1, '1, 43'd0));
        send_event(build_event(14'd10, 1'b1, '1, good, 43'd5));
        send_event(build_event(14'd16383, 1'b1, '0, good, 43'd100));
        send_event(build_event(RST_HIT_LIMIT, 1'b1, '0, good, 43'd200));
        send_event(build_event(RST_HIT_LIMIT + 14'd1, 1'b0, '1, '0, 43'd300));
        // exactly one window length after the last restart: window closes
        t = 43'd300 + 43'd1_000_000_000;
        send_event(build_event(14'd0, 1'b1, '0, good & ~RST_FOLLOWER_MASK, t));
        t = t + 43'd50;
        send_event(build_event(14'd0, 1'b1, '0, good & ~RST_FOLLOWER_MASK, t));
        t = t + 43'd10;
        send_event(build_event(14'd0, 1'b1, '0, good, t));
        t = t + 43'd1;
        send_event(build_event(14'd0, 1'b1, '1, good & ~64'h2, t));
        t = t + 43'd1;
        send_event(build_event(14'd0, 1'b1, '1, '1, t));
        t = t + 43'd1;
        send_event(build_event(14'd0, 1'b0, '0, '0, t));
        t = t + 43'd1;
        send_event(build_event(14'd0, 1'b1, '0, good & ~RST_FOLLOWER_MASK, t));
        t = t + 43'd500;
        send_event(build_event(14'd6000, 1'b1, '0, good, t));
        t = t + 43'd999_999_999;
        send_event(build_event(14'd0, 1'b1, '0, good, t));
        t = t + 43'd1;
        send_event(build_event(14'd0, 1'b1, '0, good, t));
        // tick counter wraps between window start and the next events
        send_event(build_event(14'd0, 1'b1, '0, good & ~RST_MUON_MASK, 43'h7FF_FFFF_FFF0));
        send_event(build_event(14'd0, 1'b1, '0, good, 43'd5));
        send_event(build_event(14'd16383, 1'b1, '1, '1, 43'h7FF_FFFF_FFFF));
        send_event(build_event(14'd0, 1'b1, '0, '0, 43'd0));
        settle_results();
    endtask

    task automatic test_register_extremes();
        tick_stride = 1000;
        // everything with a hit vetoes, window never holds, every applied cut counts
        load_settings(64'd0, 64'd0, 64'd0, 64'd0, '1);
        run_traffic(60);
        settle_results();
        // nothing trips on hits, window never closes, all flags required
        load_settings(64'd16383, 64'hFFFF_FFFF_FFFF, '1, '1, 64'd0);
        run_traffic(60);
        settle_results();
        // oversized writes keep only the register width; spare index is ignored
        load_settings(64'hFFFF_FFFF_FFFF_0FA0, 64'hABCD_0000_0000_4E20, 64'd0, few_bits(),
                      {$urandom, $urandom});
        write_register(CFG_SPARE_IDX, {$urandom, $urandom});
        run_traffic(60);
        settle_results();
    endtask

    task automatic test_random_traffic();
        repeat (5) begin
            tick_stride = $urandom_range(5, 300);
            load_settings(64'($urandom_range(200, 12000)), 64'($urandom_range(200, 20000)),
                          few_bits(), few_bits(),
                          $urandom_range(0, 1) ? ({$urandom, $urandom} & {$urandom, $urandom})
                                               : few_bits());
            run_traffic(140);
            settle_results();
        end
    endtask

    task automatic test_drain_pauses();
        tick_stride = 100;
        repeat (4) begin
            repeat (10) send_event(random_event());
            settle_results();
        end
    endtask

    initial begin
        clear_tracker();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_drain_pauses();
        settle_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("muon_deadtime_veto_tracker test passed");
        end else begin
            $display("muon_deadtime_veto_tracker test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("muon_deadtime_veto_tracker test failed");
        $finish;
    end

endmodule

@@ muon_deadtime_veto_tracker.f @@
design/mdvt_pkg.sv
design/mdvt_cfg.sv
design/mdvt_in_stage.sv
design/mdvt_core.sv
design/mdvt_out_stage.sv
design/muon_deadtime_veto_tracker.sv
tb/tb_muon_deadtime_veto_tracker.sv
